FILE: rtl/core/bpc_pkg.sv
package bpc_pkg;

  // width of the internal time arithmetic, time wraps modulo 2^TimeBits
  localparam int unsigned TimeBits = 32;
  localparam int unsigned NowBits = 32;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned MsBits = 16;
  localparam int unsigned CodeBits = 8;
  localparam int unsigned CountBits = 8;
  localparam int unsigned RepeatShift = 2;  // quick repeat window is long limit / 4

  localparam logic [CfgIdxBits-1:0] CfgLongPressMs = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgShortPressMs = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgLongCode = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgSingleCode = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgRepeatCode = 3'd4;

  localparam logic [MsBits-1:0] LongPressMsRst = 16'd1000;
  localparam logic [MsBits-1:0] ShortPressMsRst = 16'd50;
  localparam logic [CodeBits-1:0] LongCodeRst = 8'd0;
  localparam logic [CodeBits-1:0] SingleCodeRst = 8'd1;
  localparam logic [CodeBits-1:0] RepeatCodeRst = 8'd2;

  typedef enum logic [1:0] {
    KindLong = 2'd0,
    KindSingle = 2'd1,
    KindRepeat = 2'd2
  } kind_e;

  typedef struct packed {
    logic [MsBits-1:0] long_press_ms;
    logic [MsBits-1:0] short_press_ms;
    logic [CodeBits-1:0] long_code;
    logic [CodeBits-1:0] single_code;
    logic [CodeBits-1:0] repeat_code;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic [CodeBits-1:0] code;
    kind_e kind;
  } event_t;

endpackage

FILE: rtl/core/bpc_cfg.sv
module bpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [bpc_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output bpc_pkg::cfg_t                  cfg_o
);
  import bpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLongPressMs:  cfg_d.long_press_ms = cfg_wdata_i[MsBits-1:0];
        CfgShortPressMs: cfg_d.short_press_ms = cfg_wdata_i[MsBits-1:0];
        CfgLongCode:     cfg_d.long_code = cfg_wdata_i[CodeBits-1:0];
        CfgSingleCode:   cfg_d.single_code = cfg_wdata_i[CodeBits-1:0];
        CfgRepeatCode:   cfg_d.repeat_code = cfg_wdata_i[CodeBits-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= LongPressMsRst;
      cfg_q.short_press_ms <= ShortPressMsRst;
      cfg_q.long_code <= LongCodeRst;
      cfg_q.single_code <= SingleCodeRst;
      cfg_q.repeat_code <= RepeatCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/bpc_core.sv
module bpc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         released_i,
  input  logic [bpc_pkg::TimeBits-1:0] now_i,
  input  bpc_pkg::cfg_t                cfg_i,
  output bpc_pkg::event_t              evt_o
);
  import bpc_pkg::*;

  logic [TimeBits-1:0]  press_start_q, press_start_d;
  logic                 press_active_q, press_active_d;
  logic                 long_served_q, long_served_d;
  logic [TimeBits-1:0]  last_short_q, last_short_d;
  logic [CountBits-1:0] short_count_q, short_count_d;

  logic [TimeBits-1:0]  start_eff;
  logic [TimeBits-1:0]  elapsed;
  logic [TimeBits-1:0]  gap;
  logic [TimeBits-1:0]  long_lim;
  logic [TimeBits-1:0]  short_lim;
  logic [TimeBits-1:0]  repeat_lim;
  logic                 quick;
  logic [CountBits-1:0] count_inc;

  // a fresh press measures from the current poll
  assign start_eff = (!released_i && !press_active_q) ? now_i : press_start_q;
  assign elapsed = now_i - start_eff;
  assign gap = now_i - last_short_q;
  assign long_lim = TimeBits'(cfg_i.long_press_ms);
  assign short_lim = TimeBits'(cfg_i.short_press_ms);
  assign repeat_lim = TimeBits'(cfg_i.long_press_ms >> RepeatShift);
  assign quick = gap < repeat_lim;
  assign count_inc = (short_count_q == {CountBits{1'b1}}) ? short_count_q
                                                          : short_count_q + 1'b1;

  always_comb begin
    press_start_d = press_start_q;
    press_active_d = press_active_q;
    long_served_d = long_served_q;
    last_short_d = last_short_q;
    short_count_d = short_count_q;
    evt_o.emit = 1'b0;
    evt_o.code = cfg_i.long_code;
    evt_o.kind = KindLong;
    if (step_i) begin
      if (released_i) begin
        if (press_active_q) begin
          if (elapsed > long_lim) begin
            // held past the long limit: no short event, the press just ends
            press_active_d = 1'b0;
            long_served_d = 1'b0;
          end else if (elapsed > short_lim) begin
            press_active_d = 1'b0;
            long_served_d = 1'b0;
            short_count_d = quick ? count_inc : CountBits'(1);
            last_short_d = now_i;
            evt_o.emit = 1'b1;
            if (short_count_d == CountBits'(1)) begin
              evt_o.code = cfg_i.single_code;
              evt_o.kind = KindSingle;
            end else begin
              evt_o.code = cfg_i.repeat_code;
              evt_o.kind = KindRepeat;
            end
          end
        end
      end else begin
        press_active_d = 1'b1;
        press_start_d = start_eff;
        if (elapsed > long_lim && !long_served_q) begin
          long_served_d = 1'b1;
          evt_o.emit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_start_q <= '0;
      press_active_q <= 1'b0;
      long_served_q <= 1'b0;
      last_short_q <= '0;
      short_count_q <= '0;
    end else begin
      press_start_q <= press_start_d;
      press_active_q <= press_active_d;
      long_served_q <= long_served_d;
      last_short_q <= last_short_d;
      short_count_q <= short_count_d;
    end
  end

endmodule

FILE: rtl/core/button_press_classifier_top.sv
// channel | handshake              | payload
// in      | in_valid_i / in_ready_o | button_released_i, now_ms_i
// out     | out_valid_o / out_ready_i | event_code_o, event_kind_o
// cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// one poll per cycle unless the result register stalls; a request waits in the
// input register, is classified there and its event, if any, lands in the
// result register; the result register frees the input stage as soon as it is
// empty or taken
// reset restores the default limits and codes and clears the press state
module button_press_classifier_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            button_released_i,
  input  logic [bpc_pkg::NowBits-1:0]     now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bpc_pkg::CodeBits-1:0]    event_code_o,
  output logic [1:0]                      event_kind_o,
  input  logic                            cfg_we_i,
  input  logic [bpc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import bpc_pkg::*;

  cfg_t   cfg;
  event_t evt;

  logic                in_vld_q;
  logic                released_q;
  logic [TimeBits-1:0] now_q;
  logic                advance;
  logic                out_vld_q, out_vld_d;
  logic [CodeBits-1:0] code_q;
  kind_e               kind_q;

  assign advance = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      released_q <= button_released_i;
      now_q <= TimeBits'(now_ms_i);
    end
  end

  bpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bpc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .released_i(released_q),
    .now_i     (now_q),
    .cfg_i     (cfg),
    .evt_o     (evt)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = evt.emit;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && evt.emit) begin
      code_q <= evt.code;
      kind_q <= evt.kind;
    end
  end

  assign out_valid_o = out_vld_q;
  assign event_code_o = code_q;
  assign event_kind_o = kind_q;

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !advance)
    else $error("result register overwritten while stalled");

  // long events only come from a held button
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && evt.emit && evt.kind == KindLong |-> !released_q)
    else $error("long event on a released poll");

  // short events only come from a release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && evt.emit && evt.kind != KindLong |-> released_q)
    else $error("short event on a pressed poll");

  // a stalled result stays valid and keeps its code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(code_q))
    else $error("stalled result changed");

endmodule

FILE: dv/press_event_checker.sv
module press_event_checker
  import bpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   button_released_i,
  input  logic [NowBits-1:0]     now_ms_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [CodeBits-1:0]    event_code_i,
  input  logic [1:0]             event_kind_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output int unsigned            fail_cnt_o,
  output int unsigned            open_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CodeBits-1:0] code;
    kind_e               kind;
  } press_event_t;

  cfg_t                 settings;
  logic [TimeBits-1:0]  press_t0;
  logic [TimeBits-1:0]  last_short_t;
  logic                 held;
  logic                 long_done;
  logic [CountBits-1:0] run_len;
  press_event_t         due_events[$];
  int unsigned          errors;

  // one poll of the button: update the press state, queue the event it raises
  task automatic classify_poll(input logic released, input logic [NowBits-1:0] ms);
    logic [TimeBits-1:0] now_t;
    logic [TimeBits-1:0] elapsed;
    logic [TimeBits-1:0] gap;
    now_t = TimeBits'(ms);
    if (released) begin
      if (!held) return;
      elapsed = now_t - press_t0;
      if (elapsed > settings.long_press_ms) begin
        // held past the long limit: no short event, the press just ends
        held = 1'b0;
        long_done = 1'b0;
        return;
      end
      // not above the short limit: contact bounce, press stays pending
      if (elapsed <= settings.short_press_ms) return;
      gap = now_t - last_short_t;
      held = 1'b0;
      long_done = 1'b0;
      if (gap < (settings.long_press_ms >> RepeatShift)) begin
        if (run_len != '1) run_len = run_len + 1'b1;
      end else begin
        run_len = CountBits'(1);
      end
      last_short_t = now_t;
      if (run_len == CountBits'(1)) begin
        due_events.push_back('{code: settings.single_code, kind: KindSingle});
      end else begin
        due_events.push_back('{code: settings.repeat_code, kind: KindRepeat});
      end
      return;
    end
    if (!held) begin
      held = 1'b1;
      press_t0 = now_t;
    end
    elapsed = now_t - press_t0;
    if (elapsed > settings.long_press_ms && !long_done) begin
      long_done = 1'b1;
      due_events.push_back('{code: settings.long_code, kind: KindLong});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    press_event_t seen;
    if (!rst_ni) begin
      settings = '{long_press_ms: LongPressMsRst, short_press_ms: ShortPressMsRst,
                   long_code: LongCodeRst, single_code: SingleCodeRst,
                   repeat_code: RepeatCodeRst};
      press_t0 = '0;
      last_short_t = '0;
      held = 1'b0;
      long_done = 1'b0;
      run_len = '0;
      due_events.delete();
      errors = 0;
      fail_cnt_o <= 0;
      open_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected event, expected none, got code %0d kind %0d",
                   $time, event_code_i, event_kind_i);
        end else begin
          seen = due_events.pop_front();
          if (event_code_i !== seen.code) begin
            errors++;
            $display("%0t: event code mismatch, expected %0d, got %0d",
                     $time, seen.code, event_code_i);
          end
          if (event_kind_i !== seen.kind) begin
            errors++;
            $display("%0t: event kind mismatch, expected %0d, got %0d",
                     $time, seen.kind, event_kind_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLongPressMs:  settings.long_press_ms = cfg_wdata_i[MsBits-1:0];
          CfgShortPressMs: settings.short_press_ms = cfg_wdata_i[MsBits-1:0];
          CfgLongCode:     settings.long_code = cfg_wdata_i[CodeBits-1:0];
          CfgSingleCode:   settings.single_code = cfg_wdata_i[CodeBits-1:0];
          CfgRepeatCode:   settings.repeat_code = cfg_wdata_i[CodeBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) classify_poll(button_released_i, now_ms_i);
      fail_cnt_o <= errors;
      open_cnt_o <= due_events.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int unsigned QuietLimit = 3000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   button_released_i = 1'b1;
  logic [NowBits-1:0]     now_ms_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [CodeBits-1:0]    event_code_o;
  logic [1:0]             event_kind_o;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;

  int unsigned fail_cnt;
  int unsigned open_cnt;
  int unsigned quiet_cycles = 0;
  int unsigned polls_sent = 0;
  int unsigned cur_long = LongPressMsRst;
  int unsigned cur_short = ShortPressMsRst;
  logic [NowBits-1:0] clock_ms = '0;
  bit calm = 1'b0;

  button_press_classifier_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .button_released_i,
    .now_ms_i,
    .out_valid_o,
    .out_ready_i,
    .event_code_o,
    .event_kind_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  press_event_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i        (in_ready_o),
    .button_released_i,
    .now_ms_i,
    .out_valid_i       (out_valid_o),
    .out_ready_i,
    .event_code_i      (event_code_o),
    .event_kind_i      (event_kind_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .fail_cnt_o        (fail_cnt),
    .open_cnt_o        (open_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_poll(input logic released, input logic [NowBits-1:0] ms);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_released_i <= released;
    now_ms_i <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    polls_sent++;
  endtask

  // drop valid and wait until every event has come and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [MsBits-1:0] long_ms,
                               input logic [MsBits-1:0] short_ms,
                               input logic [CodeBits-1:0] long_code,
                               input logic [CodeBits-1:0] single_code,
                               input logic [CodeBits-1:0] repeat_code);
    // upper data bits of the code writes are junk and must be dropped
    cfg_put(CfgLongPressMs, long_ms);
    cfg_put(CfgShortPressMs, short_ms);
    cfg_put(CfgLongCode, {8'($urandom()), long_code});
    cfg_put(CfgSingleCode, {8'($urandom()), single_code});
    cfg_put(CfgRepeatCode, {8'($urandom()), repeat_code});
    cfg_put(CfgIdxBits'(CfgRepeatCode + 1 + $urandom_range(2)), 16'($urandom()));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_long = long_ms;
    cur_short = short_ms;
  endtask

  // press at clock_ms, a few held polls spread over the hold, release at the end
  task automatic run_press(input int unsigned hold, input int unsigned held_polls);
    logic [NowBits-1:0] t0;
    t0 = clock_ms;
    send_poll(1'b0, t0);
    for (int unsigned i = 1; i <= held_polls; i++) begin
      send_poll(1'b0, t0 + hold * i / held_polls);
    end
    send_poll(1'b1, t0 + hold);
    clock_ms = t0 + hold;
  endtask

  task automatic random_press();
    int unsigned pick;
    int unsigned hold;
    pick = $urandom_range(99);
    if (pick < 15) begin
      hold = $urandom_range(cur_short);
    end else if (pick < 25) begin
      hold = cur_short + $urandom_range(1);
    end else if (pick < 35) begin
      hold = cur_long + $urandom_range(1);
    end else if (pick < 50) begin
      hold = cur_long + 1 + $urandom_range(cur_long / 2 + 10);
    end else if (pick < 75) begin
      // quick taps so that repeats show up
      hold = $urandom_range(cur_short + 1, cur_short + 1 + cur_long / 8);
    end else begin
      hold = $urandom_range(cur_short + 1, cur_long);
    end
    run_press(hold, $urandom_range(3));
    if ($urandom_range(1)) begin
      clock_ms += $urandom_range(cur_long / 4);
    end else begin
      clock_ms += $urandom_range(2 * cur_long + 10);
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    logic [NowBits-1:0] jump;
    stop_at = polls_sent + budget;
    clock_ms = $urandom();
    while (polls_sent < stop_at) begin
      if ($urandom_range(99) < 10) begin
        // stray poll, may break a press halfway
        jump = $urandom();
        send_poll(1'($urandom_range(1)), jump);
        if ($urandom_range(3) == 0) clock_ms = jump;
      end else begin
        random_press();
      end
    end
  endtask

  initial begin
    logic [MsBits-1:0] rnd_long;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default limits 1000 / 50
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'd150);
    send_poll(1'b1, 32'd250);
    send_poll(1'b0, 32'd300);
    send_poll(1'b1, 32'd320);
    send_poll(1'b0, 32'd330);
    send_poll(1'b1, 32'd400);
    send_poll(1'b0, 32'd2000);
    send_poll(1'b0, 32'd2500);
    send_poll(1'b0, 32'd3001);
    send_poll(1'b0, 32'd3500);
    send_poll(1'b1, 32'd3600);
    send_poll(1'b0, 32'd5000);
    send_poll(1'b1, 32'd5050);
    send_poll(1'b1, 32'd5051);
    send_poll(1'b0, 32'd6000);
    send_poll(1'b0, 32'd7000);
    send_poll(1'b1, 32'd7000);
    send_poll(1'b0, 32'hFFFF_FFC0);
    send_poll(1'b1, 32'h0000_0020);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h0000_0050);
    run_phase(190);
    settle();

    // widest repeat window: a long run of taps saturates the repeat count
    load_settings(16'hFFFF, 16'd0, 8'hFF, 8'h00, 8'h80);
    clock_ms = $urandom();
    repeat (270) begin
      run_press(1 + $urandom_range(2), 0);
      clock_ms += $urandom_range(5);
    end
    run_phase(100);
    settle();

    load_settings(16'd0, 16'd0, 8'h00, 8'hFF, 8'h00);
    run_phase(190);
    settle();

    // short limit above long limit, and no idling on either side
    calm = 1'b1;
    load_settings(16'd100, 16'hFFFF, 8'h55, 8'hAA, 8'h0F);
    run_phase(190);
    settle();
    calm = 1'b0;

    load_settings(16'hFFFF, 16'hFFFF, 8'hF0, 8'h3C, 8'hC3);
    run_phase(150);
    settle();

    rnd_long = MsBits'($urandom_range(3000, 8));
    load_settings(rnd_long, MsBits'($urandom_range(rnd_long / 2)), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
    run_phase(190);
    settle();

    load_settings(16'd3, 16'd1, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    run_phase(190);
    settle();

    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
